/* hw/rtl/copr_pkg.sv */
// Shared types, constants and saturation helpers for the circle overlap push resolver.
package copr_pkg;

  // Fixed-point format of positions and pushes.
  localparam int FRAC_BITS = 4;

  // Operation codes of an input word.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_WALL_W = 1'b0;
  localparam logic CFG_WALL_H = 1'b1;

  // Reset values of the wall half-extents (760.0 and 560.0).
  localparam logic [14:0] WALL_W_RST = 15'd12160;
  localparam logic [14:0] WALL_H_RST = 15'd8960;

  // Contact pairs allowed per process word (two pushes each, at most 30 pushes).
  localparam logic [3:0] PAIR_MAX = 4'd15;

  // Arithmetic widths.
  localparam int D2_W   = 33;
  localparam int RAD_W  = ((D2_W + 2 * FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DVD_W  = 38;

  // One table entry.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        r;
  } entry_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_LOAD_I,
    DP_SKIP,
    DP_DIFF,
    DP_SQ_X,
    DP_SQ_Y,
    DP_SQ_S,
    DP_CMP,
    DP_SQRT_STEP,
    DP_OV,
    DP_MUL_X,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_MUL_Y,
    DP_SAVE_Y,
    DP_PUSH_I,
    DP_PUSH_J,
    DP_WALL_X,
    DP_WALL_Y,
    DP_FLUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  // Status flags from the datapath.
  typedef struct packed {
    logic go;
    logic j_done;
    logic j_present;
    logic no_contact;
    logic coincide;
    logic sqrt_done;
    logic div_done;
    logic wall_x;
    logic wall_y;
    logic emit_ok;
    logic out_free;
    logic stg_valid;
  } st_t;

  // Saturate a sign and magnitude to signed 16 bits.
  function automatic logic [15:0] sat_mag(input logic neg, input logic [DVD_W-1:0] mag);
    logic [15:0] res;
    if (!neg) begin
      res = (mag > DVD_W'(32767)) ? 16'h7FFF : mag[15:0];
    end else begin
      res = (mag > DVD_W'(32768)) ? 16'h8000 : 16'(16'd0 - mag[15:0]);
    end
    return res;
  endfunction

  // Saturate an 18-bit signed value to 16 bits.
  function automatic logic [15:0] sat_s18(input logic signed [17:0] v);
    logic [15:0] res;
    if (v > 18'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -18'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/copr_dp.sv */
// Datapath of the push resolver: table memory, multiplier, square root, divider, output stages.
module copr_dp #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  copr_pkg::cmd_t      cmd_i,
  output copr_pkg::st_t       st_o,
  input  logic                op_i,
  input  logic [3:0]          entry_index_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic [13:0]         radius_in_i,
  input  logic                present_in_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [14:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          target_index_o,
  output logic [3:0]          other_index_o,
  output logic                has_other_o,
  output logic signed [15:0]  push_x_o,
  output logic signed [15:0]  push_y_o,
  output logic                last_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int JW = $clog2(MAX_ENTRIES + 1);
  localparam int RAD_W  = copr_pkg::RAD_W;
  localparam int ROOT_W = copr_pkg::ROOT_W;
  localparam int DVD_W  = copr_pkg::DVD_W;
  localparam int FB     = copr_pkg::FRAC_BITS;

  // Table storage.
  copr_pkg::entry_t mem [MAX_ENTRIES];
  copr_pkg::entry_t rd_q;
  logic [MAX_ENTRIES-1:0] present_q;
  logic [IW-1:0] idx, rd_addr;
  logic idx_ok, wr_en;

  logic [14:0] wall_w_q, wall_h_q;

  // Working registers.
  logic [IW-1:0]       i_q;
  logic signed [15:0]  xi_q, yi_q;
  logic [13:0]         ri_q;
  logic [JW-1:0]       j_q;
  logic [3:0]          pairs_q;
  logic [15:0]         dxm_q, dym_q;
  logic                sxn_q, syn_q;
  logic [14:0]         sum_q;
  logic [copr_pkg::D2_W-1:0] d2_q;
  logic [29:0]         s2_q;
  logic [35:0]         prod_q;
  logic [RAD_W-1:0]    rad_q;
  logic [ROOT_W:0]     srem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [5:0]          cnt_q;
  logic [19:0]         ov_q;
  logic [DVD_W-1:0]    dvd_q, quo_q, qx_q, qy_q;
  logic [ROOT_W:0]     drem_q;

  // Result stage and output register.
  logic        stg_valid_q, out_valid_q;
  logic [3:0]  stg_tgt_q, stg_oth_q, out_tgt_q, out_oth_q;
  logic        stg_has_q, out_has_q, out_last_q;
  logic [15:0] stg_px_q, stg_py_q, out_px_q, out_py_q;

  logic emit, out_free;
  logic [3:0]  new_tgt, new_oth;
  logic        new_has;
  logic [15:0] new_px, new_py;

  // Input decode.
  assign idx    = IW'(entry_index_i);
  assign idx_ok = 32'(entry_index_i) < MAX_ENTRIES;
  assign wr_en  = (cmd_i.op == copr_pkg::DP_ACCEPT) && (op_i == copr_pkg::OP_WRITE) && idx_ok;
  assign rd_addr = (cmd_i.op == copr_pkg::DP_ACCEPT) ? idx : j_q[IW-1:0];

  // Memory with registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx] <= '{x: pos_x_i, y: pos_y_i, r: radius_in_i};
    end
    rd_q <= mem[rd_addr];
  end

  // Present marks and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      wall_w_q  <= copr_pkg::WALL_W_RST;
      wall_h_q  <= copr_pkg::WALL_H_RST;
    end else begin
      if (wr_en) begin
        present_q[idx] <= present_in_i;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == copr_pkg::CFG_WALL_W) begin
          wall_w_q <= cfg_data_i;
        end else begin
          wall_h_q <= cfg_data_i;
        end
      end
    end
  end

  // Shared multiplier operand selection.
  logic [15:0] mul_a;
  logic [19:0] mul_b;
  logic [35:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      copr_pkg::DP_SQ_X: begin
        mul_a = dxm_q;
        mul_b = {4'd0, dxm_q};
      end
      copr_pkg::DP_SQ_Y: begin
        mul_a = dym_q;
        mul_b = {4'd0, dym_q};
      end
      copr_pkg::DP_SQ_S: begin
        mul_a = {1'b0, sum_q};
        mul_b = {5'd0, sum_q};
      end
      copr_pkg::DP_MUL_X: begin
        mul_a = dxm_q;
        mul_b = ov_q;
      end
      copr_pkg::DP_MUL_Y: begin
        mul_a = dym_q;
        mul_b = ov_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = {20'd0, mul_a} * {16'd0, mul_b};

  // Center differences.
  logic signed [16:0] dx, dy;
  assign dx = {xi_q[15], xi_q} - {rd_q.x[15], rd_q.x};
  assign dy = {yi_q[15], yi_q} - {rd_q.y[15], rd_q.y};

  // Square root step: two radicand bits per cycle, trial value is four times the root plus one.
  logic [ROOT_W+2:0] sq_sh, sq_trial;
  logic              sq_ge;
  assign sq_sh    = {srem_q, rad_q[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // Division step: one quotient bit per cycle; the remainder stays below the divisor.
  logic [ROOT_W+1:0] dv_sh, dv_den;
  logic              dv_ge;
  assign dv_sh  = {drem_q[ROOT_W-1:0], dvd_q[DVD_W-1]};
  assign dv_den = {root_q, 1'b0} ;
  assign dv_ge  = dv_sh >= {1'b0, dv_den[ROOT_W:0]};

  // Wall tests.
  logic signed [17:0] xs, ys, wxs, wxd, wys, wyd;
  assign xs  = {{2{xi_q[15]}}, xi_q};
  assign ys  = {{2{yi_q[15]}}, yi_q};
  assign wxs = xs + $signed({3'b000, wall_w_q});
  assign wxd = $signed({3'b000, wall_w_q}) - xs;
  assign wys = ys + $signed({3'b000, wall_h_q});
  assign wyd = $signed({3'b000, wall_h_q}) - ys;

  // Working register updates.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      copr_pkg::DP_ACCEPT: begin
        i_q     <= idx;
        j_q     <= JW'(idx) + JW'(1);
        pairs_q <= '0;
      end
      copr_pkg::DP_LOAD_I: begin
        xi_q <= rd_q.x;
        yi_q <= rd_q.y;
        ri_q <= rd_q.r;
      end
      copr_pkg::DP_SKIP: begin
        j_q <= j_q + JW'(1);
      end
      copr_pkg::DP_DIFF: begin
        sxn_q <= dx[16];
        syn_q <= dy[16];
        dxm_q <= dx[16] ? 16'(-dx) : dx[15:0];
        dym_q <= dy[16] ? 16'(-dy) : dy[15:0];
        sum_q <= {1'b0, ri_q} + {1'b0, rd_q.r};
      end
      copr_pkg::DP_SQ_X: begin
        d2_q <= copr_pkg::D2_W'(prod);
      end
      copr_pkg::DP_SQ_Y: begin
        d2_q <= d2_q + copr_pkg::D2_W'(prod);
      end
      copr_pkg::DP_SQ_S: begin
        s2_q <= prod[29:0];
      end
      copr_pkg::DP_CMP: begin
        if (d2_q >= copr_pkg::D2_W'(s2_q)) begin
          j_q <= j_q + JW'(1);
        end else if (d2_q == '0) begin
          // Coincident centers push along +x by the radius sum.
          qx_q  <= DVD_W'(sum_q);
          qy_q  <= '0;
          sxn_q <= 1'b0;
          syn_q <= 1'b0;
        end
        rad_q  <= RAD_W'({d2_q, (2 * FB)'(0)});
        srem_q <= '0;
        root_q <= '0;
        cnt_q  <= '0;
      end
      copr_pkg::DP_SQRT_STEP: begin
        rad_q <= rad_q << 2;
        if (sq_ge) begin
          srem_q <= (ROOT_W + 1)'(sq_sh - sq_trial);
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q <= (ROOT_W + 1)'(sq_sh);
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
      end
      copr_pkg::DP_OV: begin
        ov_q <= 20'({sum_q, FB'(0)}) - 20'(root_q);
      end
      copr_pkg::DP_MUL_X: begin
        prod_q <= prod;
      end
      copr_pkg::DP_DIV_INIT: begin
        // Rounded quotient: (2 * num + d) / (2 * d).
        dvd_q  <= DVD_W'({prod_q, 1'b0}) + DVD_W'(root_q);
        drem_q <= '0;
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      copr_pkg::DP_DIV_STEP: begin
        dvd_q <= dvd_q << 1;
        if (dv_ge) begin
          drem_q <= (ROOT_W + 1)'(dv_sh - {1'b0, dv_den[ROOT_W:0]});
        end else begin
          drem_q <= (ROOT_W + 1)'(dv_sh);
        end
        quo_q <= {quo_q[DVD_W-2:0], dv_ge};
        cnt_q <= cnt_q + 6'd1;
      end
      copr_pkg::DP_MUL_Y: begin
        prod_q <= prod;
        qx_q   <= quo_q;
      end
      copr_pkg::DP_SAVE_Y: begin
        qy_q <= quo_q;
      end
      copr_pkg::DP_PUSH_J: begin
        j_q     <= j_q + JW'(1);
        pairs_q <= pairs_q + 4'd1;
      end
      default: begin
      end
    endcase
  end

  // Result selection for the stage.
  always_comb begin
    emit    = 1'b0;
    new_tgt = 4'(i_q);
    new_oth = 4'(j_q);
    new_has = 1'b1;
    new_px  = '0;
    new_py  = '0;
    case (cmd_i.op)
      copr_pkg::DP_PUSH_I: begin
        emit   = 1'b1;
        new_px = copr_pkg::sat_mag(sxn_q, qx_q);
        new_py = copr_pkg::sat_mag(syn_q, qy_q);
      end
      copr_pkg::DP_PUSH_J: begin
        emit    = 1'b1;
        new_tgt = 4'(j_q);
        new_oth = 4'(i_q);
        new_px  = copr_pkg::sat_mag(!sxn_q, qx_q);
        new_py  = copr_pkg::sat_mag(!syn_q, qy_q);
      end
      copr_pkg::DP_WALL_X: begin
        emit    = 1'b1;
        new_oth = '0;
        new_has = 1'b0;
        new_px  = wxs[17] ? copr_pkg::sat_s18(-wxs) : copr_pkg::sat_s18(wxd);
      end
      copr_pkg::DP_WALL_Y: begin
        emit    = 1'b1;
        new_oth = '0;
        new_has = 1'b0;
        new_py  = wys[17] ? copr_pkg::sat_s18(-wys) : copr_pkg::sat_s18(wyd);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Stage and output valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((emit && stg_valid_q) || cmd_i.op == copr_pkg::DP_FLUSH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit) begin
        stg_valid_q <= 1'b1;
      end else if (cmd_i.op == copr_pkg::DP_FLUSH) begin
        stg_valid_q <= 1'b0;
      end
    end
  end

  // Stage and output payload; the held result learns whether it is the final one.
  always_ff @(posedge clk_i) begin
    if ((emit && stg_valid_q) || cmd_i.op == copr_pkg::DP_FLUSH) begin
      out_tgt_q  <= stg_tgt_q;
      out_oth_q  <= stg_oth_q;
      out_has_q  <= stg_has_q;
      out_px_q   <= stg_px_q;
      out_py_q   <= stg_py_q;
      out_last_q <= (cmd_i.op == copr_pkg::DP_FLUSH);
    end
    if (emit) begin
      stg_tgt_q <= new_tgt;
      stg_oth_q <= new_oth;
      stg_has_q <= new_has;
      stg_px_q  <= new_px;
      stg_py_q  <= new_py;
    end
  end

  // Status back to the controller.
  always_comb begin
    st_o.go         = (op_i == copr_pkg::OP_PROCESS) && idx_ok && present_q[idx];
    st_o.j_done     = (j_q == JW'(MAX_ENTRIES)) || (pairs_q == copr_pkg::PAIR_MAX);
    st_o.j_present  = present_q[j_q[IW-1:0]];
    st_o.no_contact = d2_q >= copr_pkg::D2_W'(s2_q);
    st_o.coincide   = (d2_q == '0);
    st_o.sqrt_done  = (cnt_q == 6'(ROOT_W - 1));
    st_o.div_done   = (cnt_q == 6'(DVD_W - 1));
    st_o.wall_x     = wxs[17] || wxd[17];
    st_o.wall_y     = wys[17] || wyd[17];
    st_o.emit_ok    = !stg_valid_q || out_free;
    st_o.out_free   = out_free;
    st_o.stg_valid  = stg_valid_q;
  end

  assign out_valid_o    = out_valid_q;
  assign target_index_o = out_tgt_q;
  assign other_index_o  = out_oth_q;
  assign has_other_o    = out_has_q;
  assign push_x_o       = out_px_q;
  assign push_y_o       = out_py_q;
  assign last_o         = out_last_q;

endmodule

/* hw/rtl/copr_ctrl.sv */
// Controller state machine of the push resolver.
module copr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  copr_pkg::st_t  st_i,
  output copr_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LDI   = 5'd1;
  localparam logic [4:0] S_SCAN  = 5'd2;
  localparam logic [4:0] S_DIFF  = 5'd3;
  localparam logic [4:0] S_SQX   = 5'd4;
  localparam logic [4:0] S_SQY   = 5'd5;
  localparam logic [4:0] S_SQS   = 5'd6;
  localparam logic [4:0] S_CMP   = 5'd7;
  localparam logic [4:0] S_SQRT  = 5'd8;
  localparam logic [4:0] S_OV    = 5'd9;
  localparam logic [4:0] S_MULX  = 5'd10;
  localparam logic [4:0] S_DIVIX = 5'd11;
  localparam logic [4:0] S_DIVX  = 5'd12;
  localparam logic [4:0] S_MULY  = 5'd13;
  localparam logic [4:0] S_DIVIY = 5'd14;
  localparam logic [4:0] S_DIVY  = 5'd15;
  localparam logic [4:0] S_SAVY  = 5'd16;
  localparam logic [4:0] S_PSHI  = 5'd17;
  localparam logic [4:0] S_PSHJ  = 5'd18;
  localparam logic [4:0] S_WALX  = 5'd19;
  localparam logic [4:0] S_WALY  = 5'd20;
  localparam logic [4:0] S_FLSH  = 5'd21;

  logic [4:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath command.
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = copr_pkg::DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = copr_pkg::DP_ACCEPT;
          if (st_i.go) state_d = S_LDI;
        end
      end
      S_LDI: begin
        cmd_o.op = copr_pkg::DP_LOAD_I;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (st_i.j_done) begin
          state_d = S_WALX;
        end else if (!st_i.j_present) begin
          cmd_o.op = copr_pkg::DP_SKIP;
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.op = copr_pkg::DP_DIFF;
        state_d  = S_SQX;
      end
      S_SQX: begin
        cmd_o.op = copr_pkg::DP_SQ_X;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = copr_pkg::DP_SQ_Y;
        state_d  = S_SQS;
      end
      S_SQS: begin
        cmd_o.op = copr_pkg::DP_SQ_S;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.op = copr_pkg::DP_CMP;
        if (st_i.no_contact) begin
          state_d = S_SCAN;
        end else if (st_i.coincide) begin
          state_d = S_PSHI;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = copr_pkg::DP_SQRT_STEP;
        if (st_i.sqrt_done) state_d = S_OV;
      end
      S_OV: begin
        cmd_o.op = copr_pkg::DP_OV;
        state_d  = S_MULX;
      end
      S_MULX: begin
        cmd_o.op = copr_pkg::DP_MUL_X;
        state_d  = S_DIVIX;
      end
      S_DIVIX: begin
        cmd_o.op = copr_pkg::DP_DIV_INIT;
        state_d  = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = copr_pkg::DP_DIV_STEP;
        if (st_i.div_done) state_d = S_MULY;
      end
      S_MULY: begin
        cmd_o.op = copr_pkg::DP_MUL_Y;
        state_d  = S_DIVIY;
      end
      S_DIVIY: begin
        cmd_o.op = copr_pkg::DP_DIV_INIT;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = copr_pkg::DP_DIV_STEP;
        if (st_i.div_done) state_d = S_SAVY;
      end
      S_SAVY: begin
        cmd_o.op = copr_pkg::DP_SAVE_Y;
        state_d  = S_PSHI;
      end
      S_PSHI: begin
        if (st_i.emit_ok) begin
          cmd_o.op = copr_pkg::DP_PUSH_I;
          state_d  = S_PSHJ;
        end
      end
      S_PSHJ: begin
        if (st_i.emit_ok) begin
          cmd_o.op = copr_pkg::DP_PUSH_J;
          state_d  = S_SCAN;
        end
      end
      S_WALX: begin
        if (!st_i.wall_x) begin
          state_d = S_WALY;
        end else if (st_i.emit_ok) begin
          cmd_o.op = copr_pkg::DP_WALL_X;
          state_d  = S_WALY;
        end
      end
      S_WALY: begin
        if (!st_i.wall_y) begin
          state_d = S_FLSH;
        end else if (st_i.emit_ok) begin
          cmd_o.op = copr_pkg::DP_WALL_Y;
          state_d  = S_FLSH;
        end
      end
      S_FLSH: begin
        if (!st_i.stg_valid) begin
          state_d = S_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.op = copr_pkg::DP_FLUSH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/circle_overlap_push_resolver.sv */
// Top level of the circle overlap push resolver: controller, datapath and checks.
//
//   channel | direction | handshake             | word
//   in      | input     | in_valid_i/in_stall_o | op, index, center, radius, present
//   out     | output    | out_valid_o/out_stall_i | target, other, push, last
//   cfg     | input     | cfg_valid_i/cfg_ready_o | register index, data
//
// A process word scans every later entry. A contact with coincident centers goes straight
// to its push pair; any other contact first takes 21 square root steps and two 38-step
// divisions.
// Reset clears the present marks; the table needs no clearing pass.
// A stalled output holds back only the push engine; the final push waits in a stage.
module circle_overlap_push_resolver #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic [13:0]        radius_in_i,
  input  logic               present_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         target_index_o,
  output logic [3:0]         other_index_o,
  output logic               has_other_o,
  output logic signed [15:0] push_x_o,
  output logic signed [15:0] push_y_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [14:0]        cfg_data_i
);

  copr_pkg::cmd_t cmd;
  copr_pkg::st_t  st;

  assign cfg_ready_o = 1'b1;

  copr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  copr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .st_o           (st),
    .op_i           (op_i),
    .entry_index_i  (entry_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .radius_in_i    (radius_in_i),
    .present_in_i   (present_in_i),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_index_o (target_index_o),
    .other_index_o  (other_index_o),
    .has_other_o    (has_other_o),
    .push_x_o       (push_x_o),
    .push_y_o       (push_y_o),
    .last_o         (last_o)
  );

  // An accepted word always reaches the datapath.
  a_accept_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (cmd.op == copr_pkg::DP_ACCEPT))
    else $error("accepted word not passed to datapath");

  // A push enters the stage only when the held one can move on.
  a_emit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == copr_pkg::DP_PUSH_I || cmd.op == copr_pkg::DP_PUSH_J ||
     cmd.op == copr_pkg::DP_WALL_X || cmd.op == copr_pkg::DP_WALL_Y) |-> st.emit_ok)
    else $error("push issued without room");

  // The final push leaves only from a full stage into a free output.
  a_flush_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == copr_pkg::DP_FLUSH) |-> (st.out_free && st.stg_valid))
    else $error("flush without room or result");

  // Wall pushes carry no partner entry.
  a_wall_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_other_o) |-> (other_index_o == 4'd0))
    else $error("wall push with partner index");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the circle overlap push resolver.
module testbench;

  localparam int NUM_ENTRIES = 16;
  localparam int SETTLE_CYCLES = 2000;
  localparam int HOLD_CYCLES = 3000;

  // One push as seen on the output channel.
  typedef struct packed {
    logic [3:0]         tgt;
    logic [3:0]         oth;
    logic               has;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic               last;
  } push_t;

  // One row of the directed table.
  typedef struct {
    logic               op;
    logic [3:0]         idx;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        r;
    logic               pres;
    int                 n_typed;  // -1: use the shadow table, else 0 or 1 pushes typed in
    push_t              typed;
  } row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               op_i;
  logic [3:0]         entry_index_i;
  logic signed [15:0] pos_x_i;
  logic signed [15:0] pos_y_i;
  logic [13:0]        radius_in_i;
  logic               present_in_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [3:0]         target_index_o;
  logic [3:0]         other_index_o;
  logic               has_other_o;
  logic signed [15:0] push_x_o;
  logic signed [15:0] push_y_o;
  logic               last_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [14:0]        cfg_data_i;

  // Shadow copy of the circle table and wall registers.
  logic signed [15:0] shadow_x [NUM_ENTRIES];
  logic signed [15:0] shadow_y [NUM_ENTRIES];
  logic [13:0]        shadow_r [NUM_ENTRIES];
  logic               shadow_present [NUM_ENTRIES];
  logic [14:0]        wall_w;
  logic [14:0]        wall_h;

  push_t pending_pushes [$];
  int    fail_count;
  bit    hold_req;

  circle_overlap_push_resolver DUT (.*);

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #40000000;
    $display("status: fail");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Divide rounding to nearest, ties away from zero; den is positive.
  function automatic longint round_div(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic push_t make_push(input int t, input int o, input logic h,
                                      input longint vx, input longint vy);
    push_t p;
    p.tgt = t[3:0];
    p.oth = o[3:0];
    p.has = h;
    p.px = clamp16(vx);
    p.py = clamp16(vy);
    p.last = 1'b0;
    return p;
  endfunction

  // Update the shadow table for one word and return the pushes it causes.
  task automatic resolve_word(input logic op, input logic [3:0] idx, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic [13:0] r,
                              input logic pres, output push_t res [$]);
    longint xi, yi, dx, dy, sum, d2, d, ov, vx, vy, w, h;
    int i;
    res = {};
    i = idx;
    if (op == copr_pkg::OP_WRITE) begin
      shadow_x[i] = x;
      shadow_y[i] = y;
      shadow_r[i] = r;
      shadow_present[i] = pres;
      return;
    end
    if (!shadow_present[i]) return;
    xi = shadow_x[i];
    yi = shadow_y[i];
    for (int j = i + 1; j < NUM_ENTRIES && res.size() + 2 <= 30; j++) begin
      if (!shadow_present[j]) continue;
      dx = xi - longint'(shadow_x[j]);
      dy = yi - longint'(shadow_y[j]);
      sum = longint'(shadow_r[i]) + longint'(shadow_r[j]);
      d2 = dx * dx + dy * dy;
      if (d2 >= sum * sum) continue;
      if (d2 == 0) begin
        vx = sum;
        vy = 0;
      end else begin
        d = int_sqrt(d2 << (2 * copr_pkg::FRAC_BITS));
        ov = (sum << copr_pkg::FRAC_BITS) - d;
        vx = round_div(dx * ov, d);
        vy = round_div(dy * ov, d);
      end
      res.push_back(make_push(i, j, 1'b1, vx, vy));
      res.push_back(make_push(j, i, 1'b1, -vx, -vy));
    end
    w = wall_w;
    h = wall_h;
    if (xi < -w) res.push_back(make_push(i, 0, 1'b0, -(xi + w), 0));
    else if (xi > w) res.push_back(make_push(i, 0, 1'b0, w - xi, 0));
    if (yi < -h) res.push_back(make_push(i, 0, 1'b0, 0, -(yi + h)));
    else if (yi > h) res.push_back(make_push(i, 0, 1'b0, 0, h - yi));
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
  endtask

  // Offer one word; a random gap precedes it, otherwise valid stays high.
  task automatic send_word(input logic op, input logic [3:0] idx, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic [13:0] r,
                           input logic pres, input int n_typed, input push_t typed);
    push_t res [$];
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    entry_index_i <= idx;
    pos_x_i <= x;
    pos_y_i <= y;
    radius_in_i <= r;
    present_in_i <= pres;
    do @(posedge clk_i); while (in_stall_o);
    resolve_word(op, idx, x, y, r, pres, res);
    if (n_typed < 0) begin
      foreach (res[k]) pending_pushes.push_back(res[k]);
    end else if (n_typed == 1) begin
      pending_pushes.push_back(typed);
    end
  endtask

  // Wait until idle, then write one wall register.
  task automatic write_wall(input logic idx, input logic [14:0] data);
    in_valid_i <= 1'b0;
    wait (pending_pushes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == copr_pkg::CFG_WALL_W) wall_w = data;
    else wall_h = data;
  endtask

  // Random word: mostly clustered circles near the origin, some full-range noise.
  task automatic send_random();
    logic op;
    logic [3:0] idx;
    logic signed [15:0] x, y;
    logic [13:0] r;
    logic pres;
    push_t none;
    none = '0;
    op = ($urandom_range(0, 9) < 5) ? copr_pkg::OP_PROCESS : copr_pkg::OP_WRITE;
    idx = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 5) == 0) begin
      x = 16'($urandom);
      y = 16'($urandom);
      r = 14'($urandom);
    end else begin
      x = 16'(int'($urandom_range(0, 1200)) - 600);
      y = 16'(int'($urandom_range(0, 1200)) - 600);
      r = 14'($urandom_range(0, 400));
    end
    pres = ($urandom_range(0, 7) != 0);
    send_word(op, idx, x, y, r, pres, -1, none);
  endtask

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    int hold_left;
    bit hold_done;
    out_stall_i = 1'b0;
    mode = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Compare each accepted push with the oldest expectation.
  always @(posedge clk_i) begin
    push_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pushes.size() == 0) begin
        $error("unexpected push to entry %0d", target_index_o);
        fail_count++;
      end else begin
        want = pending_pushes.pop_front();
        if (target_index_o !== want.tgt) begin
          $error("target_index: expected %0d, got %0d", want.tgt, target_index_o);
          fail_count++;
        end
        if (other_index_o !== want.oth) begin
          $error("other_index: expected %0d, got %0d", want.oth, other_index_o);
          fail_count++;
        end
        if (has_other_o !== want.has) begin
          $error("has_other: expected %0d, got %0d", want.has, has_other_o);
          fail_count++;
        end
        if (push_x_o !== want.px) begin
          $error("push_x: expected %0d, got %0d", want.px, push_x_o);
          fail_count++;
        end
        if (push_y_o !== want.py) begin
          $error("push_y: expected %0d, got %0d", want.py, push_y_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    row_t rows [$];
    row_t rw;
    push_t none;
    none = '0;
    fail_count = 0;
    hold_req = 0;
    wall_w = copr_pkg::WALL_W_RST;
    wall_h = copr_pkg::WALL_H_RST;
    foreach (shadow_present[k]) begin
      shadow_present[k] = 1'b0;
      shadow_x[k] = '0;
      shadow_y[k] = '0;
      shadow_r[k] = '0;
    end
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = copr_pkg::OP_WRITE;
    entry_index_i = '0;
    pos_x_i = '0;
    pos_y_i = '0;
    radius_in_i = '0;
    present_in_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = copr_pkg::CFG_WALL_W;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: lone circles, wall extremes, coincident centers, removal, top entry.
    rows = '{
      '{copr_pkg::OP_PROCESS, 4'd7, 16'sd0, 16'sd0, 14'd0, 1'b0, 0, none},
      '{copr_pkg::OP_WRITE, 4'd0, 16'sd0, 16'sd0, 14'd16, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd0, 16'sd0, 16'sd0, 14'd0, 1'b0, 0, none},
      '{copr_pkg::OP_WRITE, 4'd0, 16'sd32767, 16'sd0, 14'd0, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd0, 16'sd0, 16'sd0, 14'd0, 1'b0, 1,
        '{4'd0, 4'd0, 1'b0, -16'sd20607, 16'sd0, 1'b1}},
      '{copr_pkg::OP_WRITE, 4'd1, -16'sd32768, -16'sd32768, 14'd16383, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd1, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none},
      '{copr_pkg::OP_WRITE, 4'd2, 16'sd100, 16'sd100, 14'd50, 1'b1, 0, none},
      '{copr_pkg::OP_WRITE, 4'd3, 16'sd100, 16'sd100, 14'd30, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd2, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none},
      '{copr_pkg::OP_WRITE, 4'd3, 16'sd100, 16'sd100, 14'd30, 1'b0, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd2, 16'sd0, 16'sd0, 14'd0, 1'b0, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd3, 16'sd0, 16'sd0, 14'd0, 1'b0, 0, none},
      '{copr_pkg::OP_WRITE, 4'd4, 16'sd0, 16'sd0, 14'd16383, 1'b1, 0, none},
      '{copr_pkg::OP_WRITE, 4'd5, 16'sd1, 16'sd0, 14'd16383, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd4, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none},
      '{copr_pkg::OP_WRITE, 4'd15, -16'sd1, 16'sd32767, 14'd16383, 1'b1, 0, none},
      '{copr_pkg::OP_PROCESS, 4'd15, 16'sd0, 16'sd0, 14'd0, 1'b0, 1,
        '{4'd15, 4'd0, 1'b0, 16'sd0, -16'sd23807, 1'b1}},
      '{copr_pkg::OP_PROCESS, 4'd5, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none},
      '{copr_pkg::OP_PROCESS, 4'd1, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none}
    };
    foreach (rows[k]) begin
      rw = rows[k];
      send_word(rw.op, rw.idx, rw.x, rw.y, rw.r, rw.pres, rw.n_typed, rw.typed);
    end

    // Random phases over several wall settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1: begin
          write_wall(copr_pkg::CFG_WALL_W, 15'd0);
          write_wall(copr_pkg::CFG_WALL_H, 15'd0);
        end
        2: begin
          write_wall(copr_pkg::CFG_WALL_W, 15'd32767);
          write_wall(copr_pkg::CFG_WALL_H, 15'd32767);
        end
        3: begin
          write_wall(copr_pkg::CFG_WALL_W, 15'($urandom_range(0, 9000)));
          write_wall(copr_pkg::CFG_WALL_H, 15'($urandom_range(0, 9000)));
        end
        default: ;
      endcase
      if (ph == 1) begin
        // Walls at zero: saturating wall pushes from the extreme corners.
        send_word(copr_pkg::OP_WRITE, 4'd14, 16'sh8000, 16'sh7FFF, 14'd0, 1'b1, -1, none);
        send_word(copr_pkg::OP_PROCESS, 4'd14, 16'sd0, 16'sd0, 14'd0, 1'b0, -1, none);
      end
      for (int n = 0; n < 52; n++) begin
        if (ph == 2 && n == 10) hold_req = 1;
        send_random();
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_pushes.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_pushes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* circle_overlap_push_resolver.f */
hw/rtl/copr_pkg.sv
hw/rtl/copr_dp.sv
hw/rtl/copr_ctrl.sv
hw/rtl/circle_overlap_push_resolver.sv
tb/sv/testbench.sv
